[hw/rtl/tlbfl_pkg.sv]
// Shared types and constants for the TLB with FIFO/LRU replacement.
// No dependencies; the top level and tlbfl_regs refer to it by scoped names.
`default_nettype none

package tlbfl_pkg;

	// Width of the access counter and of each entry's stamp.
	localparam int STAMP_W = 32;

	// Width of the entry-count register.
	localparam int CFG_SIZE_W = 5;

	// Operation codes carried in the op field of an item.
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	// Register index, taken from paddr[2].
	localparam logic REG_ENTRIES = 1'b0;
	localparam logic REG_LRU     = 1'b1;

	// Configuration as seen by the lookup engine.
	typedef struct packed {
		logic [CFG_SIZE_W-1:0] entries_in_use;
		logic                  use_lru;
	} tlbfl_cfg_t;

endpackage

`default_nettype wire

[hw/rtl/tlbfl_if.sv]
// Valid/ready channel interfaces for the TLB request and response items.
// Depends on nothing; widths are set by the parameters of each instance.
`default_nettype none

interface tlbfl_req_if #(
	parameter int PID_BITS   = 16,
	parameter int PAGE_BITS  = 20,
	parameter int FRAME_BITS = 20
) ();
	logic                  valid;
	logic                  ready;
	logic                  op;
	logic [PID_BITS-1:0]   process_id;
	logic [PAGE_BITS-1:0]  page_number;
	logic [FRAME_BITS-1:0] frame_number;

	modport source (output valid, op, process_id, page_number, frame_number, input ready);
	modport sink   (input valid, op, process_id, page_number, frame_number, output ready);
endinterface

interface tlbfl_rsp_if #(
	parameter int FRAME_BITS = 20
) ();
	logic                  valid;
	logic                  ready;
	logic                  hit;
	logic [FRAME_BITS-1:0] frame_out;

	modport source (output valid, hit, frame_out, input ready);
	modport sink   (input valid, hit, frame_out, output ready);
endinterface

`default_nettype wire

[hw/rtl/tlb_fifo_lru_replacement.sv]
// Top level of the fully associative TLB with FIFO or LRU replacement.
// Depends on tlbfl_pkg, tlbfl_req_if/tlbfl_rsp_if, tlbfl_ram and tlbfl_regs.
`default_nettype none

// Channel   Dir  Handshake        Payload
// req       in   valid/ready      op, process_id, page_number, frame_number
// rsp       out  valid/ready      hit, frame_out
// APB       in   psel/penable     paddr, pwdata, prdata (pready always high)
//
// An item is taken only while the engine is idle. A lookup scans the
// live entries through the single read port of the entry memory, one entry per
// cycle, and stops at the first match. An insert into a table that is not yet
// full writes the new entry on accept; a replacement scans all usable entries
// for the oldest stamp and then writes back into that slot.
// Reset clears the fill count, the access counter and the control state; the
// entry memory itself is not cleared, as only filled entries are ever read.
// A result that is not taken holds in the output register; the next item is
// accepted meanwhile, and its result waits until the register is free.

module tlb_fifo_lru_replacement #(
	parameter int MAX_ENTRIES = 16,
	parameter int PID_BITS    = 16,
	parameter int PAGE_BITS   = 20,
	parameter int FRAME_BITS  = 20
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	tlbfl_req_if.sink        req,
	tlbfl_rsp_if.source      rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int STAMP_W = tlbfl_pkg::STAMP_W;
	localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W   = (CNT_W > tlbfl_pkg::CFG_SIZE_W) ? CNT_W : tlbfl_pkg::CFG_SIZE_W;
	localparam int WORD_W  = PID_BITS + PAGE_BITS + FRAME_BITS + STAMP_W;

	// The engine walks through these states once per item, skipping those it does not need.
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_WRITE = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	tlbfl_pkg::tlbfl_cfg_t cfg;

	tlbfl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Control state.
	state_t               state_q;
	logic [CNT_W-1:0]     fill_q;
	logic [STAMP_W-1:0]   clock_q;
	logic [CNT_W-1:0]     limit_q;
	logic [CNT_W-1:0]     issue_q;
	logic [CNT_W-1:0]     cmp_q;
	logic                 out_valid_q;

	// The item in flight and the scan results.
	logic                  op_q;
	logic [PID_BITS-1:0]   pid_q;
	logic [PAGE_BITS-1:0]  page_q;
	logic [FRAME_BITS-1:0] frame_in_q;
	logic [STAMP_W-1:0]    min_q;
	logic [IDX_W-1:0]      victim_q;
	logic                  res_hit_q;
	logic [FRAME_BITS-1:0] res_frame_q;
	logic                  out_hit_q;
	logic [FRAME_BITS-1:0] out_frame_q;

	// Entry memory ports.
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [WORD_W-1:0] wr_data;

	tlbfl_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_ENTRIES)
	) u_entries (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Fields of the entry that was read in the previous cycle.
	logic [PID_BITS-1:0]   rd_pid;
	logic [PAGE_BITS-1:0]  rd_page;
	logic [FRAME_BITS-1:0] rd_frame;
	logic [STAMP_W-1:0]    rd_stamp;

	assign rd_pid   = rd_data[WORD_W-1 -: PID_BITS];
	assign rd_page  = rd_data[WORD_W-PID_BITS-1 -: PAGE_BITS];
	assign rd_frame = rd_data[STAMP_W +: FRAME_BITS];
	assign rd_stamp = rd_data[STAMP_W-1:0];

	// A register value above the capacity acts as the capacity. Only entries
	// below both the fill count and the usable size take part.
	logic [CMP_W-1:0] cfg_size_ext;
	logic [CMP_W-1:0] max_ext;
	logic [CNT_W-1:0] size_c;
	logic [CNT_W-1:0] live_c;
	logic             has_room_c;

	assign cfg_size_ext = CMP_W'(cfg.entries_in_use);
	assign max_ext      = CMP_W'(MAX_ENTRIES);
	assign size_c       = CNT_W'((cfg_size_ext > max_ext) ? max_ext : cfg_size_ext);
	assign has_room_c   = fill_q < size_c;
	assign live_c       = has_room_c ? fill_q : size_c;

	logic accept_c;
	logic match_c;
	logic last_c;
	logic take_c;
	logic more_c;
	logic load_out_c;

	assign req.ready = (state_q == ST_IDLE);
	assign accept_c  = req.valid && req.ready;
	assign match_c   = (rd_pid == pid_q) && (rd_page == page_q);
	assign last_c    = (cmp_q + CNT_W'(1)) == limit_q;
	assign take_c    = (cmp_q == '0) || (rd_stamp < min_q);
	assign more_c    = issue_q < limit_q;

	// The finished result moves into the output register once that is empty or
	// is being emptied in the same cycle.
	assign load_out_c = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	assign rsp.valid     = out_valid_q;
	assign rsp.hit       = out_hit_q;
	assign rsp.frame_out = out_frame_q;

	// Memory port control. Reads run one entry ahead of the compare; writes are
	// an append on accept, an LRU refresh on a hit, or a replacement after the
	// scan. Only one item is in flight, so reads and writes never collide.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept_c && (size_c != '0)) begin
					if (req.op == tlbfl_pkg::OP_LOOKUP) begin
						rd_en = (live_c != '0);
					end else if (has_room_c) begin
						wr_en   = 1'b1;
						wr_addr = fill_q[IDX_W-1:0];
						wr_data = {req.process_id, req.page_number, req.frame_number,
						           clock_q + STAMP_W'(1)};
					end else begin
						rd_en = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (more_c) begin
					rd_en   = 1'b1;
					rd_addr = issue_q[IDX_W-1:0];
				end
				if ((op_q == tlbfl_pkg::OP_LOOKUP) && match_c && cfg.use_lru) begin
					wr_en   = 1'b1;
					wr_addr = cmp_q[IDX_W-1:0];
					wr_data = {rd_pid, rd_page, rd_frame, clock_q};
				end
			end
			ST_WRITE: begin
				wr_en   = 1'b1;
				wr_addr = victim_q;
				wr_data = {pid_q, page_q, frame_in_q, clock_q};
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			clock_q     <= '0;
			limit_q     <= '0;
			issue_q     <= '0;
			cmp_q       <= '0;
			out_valid_q <= 1'b0;
			op_q        <= tlbfl_pkg::OP_LOOKUP;
			pid_q       <= '0;
			page_q      <= '0;
			frame_in_q  <= '0;
			min_q       <= '0;
			victim_q    <= '0;
			res_hit_q   <= 1'b0;
			res_frame_q <= '0;
			out_hit_q   <= 1'b0;
			out_frame_q <= '0;
		end else begin
			if (load_out_c) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept_c) begin
						// Every item advances the access counter, even when disabled.
						clock_q     <= clock_q + STAMP_W'(1);
						op_q        <= req.op;
						pid_q       <= req.process_id;
						page_q      <= req.page_number;
						frame_in_q  <= req.frame_number;
						res_hit_q   <= 1'b0;
						res_frame_q <= '0;
						cmp_q       <= '0;
						issue_q     <= CNT_W'(1);
						if (size_c == '0) begin
							state_q <= ST_DONE;
						end else if (req.op == tlbfl_pkg::OP_LOOKUP) begin
							limit_q <= live_c;
							state_q <= (live_c == '0) ? ST_DONE : ST_SCAN;
						end else if (has_room_c) begin
							fill_q  <= fill_q + CNT_W'(1);
							state_q <= ST_DONE;
						end else begin
							limit_q <= size_c;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (more_c) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					cmp_q <= cmp_q + CNT_W'(1);
					if (op_q == tlbfl_pkg::OP_LOOKUP) begin
						if (match_c) begin
							res_hit_q   <= 1'b1;
							res_frame_q <= rd_frame;
							state_q     <= ST_DONE;
						end else if (last_c) begin
							state_q <= ST_DONE;
						end
					end else begin
						// Strict compare keeps the lowest slot on equal stamps.
						if (take_c) begin
							min_q    <= rd_stamp;
							victim_q <= cmp_q[IDX_W-1:0];
						end
						if (last_c) begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out_c) begin
						out_hit_q   <= res_hit_q;
						out_frame_q <= res_frame_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/tlbfl_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module tlbfl_ram #(
	parameter int WIDTH = 88,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/tlbfl_regs.sv]
// APB-style configuration registers for the TLB: entry count and LRU enable.
// Depends on tlbfl_pkg for the register indices and the configuration struct.
`default_nettype none

module tlbfl_regs (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	output tlbfl_pkg::tlbfl_cfg_t   cfg
);

	tlbfl_pkg::tlbfl_cfg_t cfg_q;
	logic                  wr_c;

	assign pready = 1'b1;
	assign wr_c   = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_c) begin
			unique case (paddr[2])
				tlbfl_pkg::REG_ENTRIES: begin
					cfg_q.entries_in_use <= pwdata[tlbfl_pkg::CFG_SIZE_W-1:0];
				end
				tlbfl_pkg::REG_LRU: begin
					cfg_q.use_lru <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			tlbfl_pkg::REG_ENTRIES: begin
				prdata[tlbfl_pkg::CFG_SIZE_W-1:0] = cfg_q.entries_in_use;
			end
			tlbfl_pkg::REG_LRU: begin
				prdata[0] = cfg_q.use_lru;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
